[rtl/core/svpm_pkg.sv]
// Shared types and constants of the Sv39 page table mapper.
// Holds request/result layouts, operation and status codes, and entry formats.
// No dependencies.
package svpm_pkg;

   localparam int VA_W              = 39;
   localparam int PA_W              = 56;
   localparam int PROT_W            = 8;
   localparam int COUNT_W           = 21;
   localparam int PPN_W             = 44;
   localparam int VPN_W             = 9;
   localparam int VPN_ALL_W         = 27;
   localparam int ENTRY_W           = 64;
   localparam int PAGE_SHIFT        = 12;
   localparam int PTE_PPN_LSB       = 10;
   localparam int ENTRIES_PER_TABLE = 512;

   localparam logic [ENTRY_W-1:0] PTE_V          = 64'h1;
   localparam logic [ENTRY_W-1:0] PTE_LEAF_FLAGS = 64'hc1;

   localparam logic [1:0] LVL_ROOT = 2'd2;
   localparam logic [1:0] LVL_MID  = 2'd1;
   localparam logic [1:0] LVL_LEAF = 2'd0;

   localparam logic [VPN_ALL_W-1:0] VPN_STEP_4K = VPN_ALL_W'(1);
   localparam logic [VPN_ALL_W-1:0] VPN_STEP_2M = VPN_ALL_W'(ENTRIES_PER_TABLE);
   localparam logic [PPN_W-1:0]     PPN_STEP_4K = PPN_W'(1);
   localparam logic [PPN_W-1:0]     PPN_STEP_2M = PPN_W'(ENTRIES_PER_TABLE);

   typedef enum logic [1:0] {
      OP_MAP_4K = 2'd0,
      OP_MAP_2M = 2'd1,
      OP_UNMAP  = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_OUTSIDE = 2'd3
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [VPN_ALL_W-1:0]   vpn;
      logic [PPN_W-1:0]       ppn;
      logic [PROT_W-1:0]      prot;
      logic [COUNT_W-1:0]     count;
   } request_type;

   typedef struct packed {
      status_type             status;
      logic [ENTRY_W-1:0]     value;
   } result_type;

   function automatic logic [VPN_W-1:0] vpn_at(input logic [VPN_ALL_W-1:0] vpn,
                                               input logic [1:0] level);
      logic [VPN_W-1:0] slot;
      case (level)
         LVL_ROOT: slot = vpn[26:18];
         LVL_MID:  slot = vpn[17:9];
         default:  slot = vpn[8:0];
      endcase
      return slot;
   endfunction

endpackage

[rtl/core/sv39_page_table_mapper_unit.sv]
// Usage: Sv39 page table mapper. Requests enter on req_*, one response per
// request leaves on rsp_*, table_base_ppn is written on csr_*.
// req_tuser carries the operation: map 4K run, map 2M run, unmap, lookup.
// The three-level table lives in one store of TABLE_PAGES x 512 entries;
// the root is table 0 and new tables come from a bump counter.
// After reset the store is swept to zero, one entry a cycle, over all
// TABLE_PAGES*512 entries (32768 by default); req_tready stays low meanwhile.
// Each page of a map run is walked anew from the root; a table missing on
// the way is taken from the bump counter, its 512 entries are zeroed, and
// it is then linked into its parent entry.
// One request is worked on at a time. The response is held in an output
// register; while the receiver stalls the next request is still taken and
// walked, and its response waits until the register frees.
// Depends on svpm_pkg, svpm_walker and svpm_ram.
module sv39_page_table_mapper_unit import svpm_pkg::*; #(
   parameter int TABLE_PAGES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [38:0] virt_addr, [94:39] phys_addr, [102:95] prot_bits,
   // [123:103] page_count, [127:124] zero
   input  logic [127:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] entry_value
   output logic [63:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [43:0]  csr_data
);

   localparam int TABLE_W = $clog2(TABLE_PAGES);
   localparam int ADDR_W  = TABLE_W + VPN_W;
   localparam int DEPTH   = TABLE_PAGES * ENTRIES_PER_TABLE;

   logic [PPN_W-1:0]   base_ppn_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   request_type        req;
   logic               res_valid;
   result_type         res;
   logic               res_ready;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   assign req.op    = op_type'(req_tuser);
   assign req.vpn   = req_tdata[VA_W-1:PAGE_SHIFT];
   assign req.ppn   = req_tdata[VA_W+PA_W-1:VA_W+PAGE_SHIFT];
   assign req.prot  = req_tdata[VA_W+PA_W+PROT_W-1:VA_W+PA_W];
   assign req.count = req_tdata[VA_W+PA_W+PROT_W+COUNT_W-1:VA_W+PA_W+PROT_W];

   assign csr_ready  = 1'b1;
   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.status;

   svpm_walker #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .base_ppn  (base_ppn_ff),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   svpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ppn_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            base_ppn_ff <= csr_data;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   a_value_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("nonzero entry value with failing status");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_tvalid)
      else $error("walker result lost before response register");
`endif

endmodule

[rtl/core/svpm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module svpm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32768,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/svpm_walker.sv]
// Table walk sequencer: clears the store, walks, allocates, zeroes and writes entries.
// Depends on svpm_pkg; drives the ports of one svpm_ram.
module svpm_walker import svpm_pkg::*; #(
   parameter int TABLE_PAGES = 64,
   localparam int TABLE_W = $clog2(TABLE_PAGES),
   localparam int ADDR_W  = TABLE_W + VPN_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PPN_W-1:0]   base_ppn,
   input  logic               req_valid,
   input  request_type        req,
   output logic               req_ready,
   output logic               res_valid,
   output result_type         res,
   input  logic               res_ready,
   output logic               mem_we,
   output logic [ADDR_W-1:0]  mem_waddr,
   output logic [ENTRY_W-1:0] mem_wdata,
   output logic [ADDR_W-1:0]  mem_raddr,
   input  logic [ENTRY_W-1:0] mem_rdata
);

   localparam int FREE_W = $clog2(TABLE_PAGES + 1);
   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_READ  = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_ZERO  = 9'b000010000,
      S_LINK  = 9'b000100000,
      S_LEAF  = 9'b001000000,
      S_LOOK  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   request_type        req_ff, req_in;
   logic [1:0]         level_ff, level_in;
   logic [TABLE_W-1:0] parent_ff, parent_in;
   logic [TABLE_W-1:0] child_ff, child_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   status_type         status_ff, status_in;
   logic [ENTRY_W-1:0] value_ff, value_in;

   logic [VPN_W-1:0]   slot;
   logic [PPN_W-1:0]   tbl_ofs;
   logic               in_store;
   logic               go_read;
   logic               is_map;
   logic               is_2m;
   logic [PPN_W-1:0]   link_ppn;
   logic [ENTRY_W-1:0] leaf_value;
   logic [ENTRY_W-1:0] link_value;

   assign slot       = vpn_at(req_ff.vpn, level_ff);
   assign tbl_ofs    = mem_rdata[PTE_PPN_LSB +: PPN_W] - base_ppn;
   assign in_store   = tbl_ofs < PPN_W'(TABLE_PAGES);
   assign go_read    = (level_ff == LVL_ROOT) && (req_ff.op != OP_MAP_2M);
   assign is_map     = (req_ff.op == OP_MAP_4K) || (req_ff.op == OP_MAP_2M);
   assign is_2m      = (req_ff.op == OP_MAP_2M);
   assign link_ppn   = base_ppn + PPN_W'(child_ff);
   assign leaf_value = {10'd0, req_ff.ppn, 2'd0, req_ff.prot} | PTE_LEAF_FLAGS;
   assign link_value = {10'd0, link_ppn, 10'd0} | PTE_V;

   assign mem_raddr = {parent_ff, slot};
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = '{status: status_ff, value: value_ff};

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      level_in  = level_ff;
      parent_in = parent_ff;
      child_in  = child_ff;
      sweep_in  = sweep_ff;
      free_in   = free_ff;
      status_in = status_ff;
      value_in  = value_ff;
      mem_we    = 1'b0;
      mem_waddr = {parent_ff, slot};
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req;
               level_in  = LVL_ROOT;
               parent_in = '0;
               status_in = ST_OK;
               value_in  = '0;
               if ((req.op == OP_MAP_4K || req.op == OP_MAP_2M) && req.count == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (mem_rdata[0]) begin
               if (!in_store) begin
                  status_in = ST_OUTSIDE;
                  state_in  = S_DONE;
               end else begin
                  parent_in = tbl_ofs[TABLE_W-1:0];
                  level_in  = level_ff - 2'd1;
                  state_in  = go_read ? S_READ : S_LEAF;
               end
            end else if (!is_map) begin
               status_in = ST_MISSING;
               state_in  = S_DONE;
            end else if (free_ff >= FREE_W'(TABLE_PAGES)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               child_in = free_ff[TABLE_W-1:0];
               free_in  = free_ff + FREE_W'(1);
               sweep_in = '0;
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = {child_ff, sweep_ff[VPN_W-1:0]};
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff[VPN_W-1:0] == '1) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            mem_we    = 1'b1;
            mem_wdata = link_value;
            parent_in = child_ff;
            level_in  = level_ff - 2'd1;
            state_in  = go_read ? S_READ : S_LEAF;
         end
         S_LEAF: begin
            if (req_ff.op == OP_LOOKUP) begin
               state_in = S_LOOK;
            end else if (req_ff.op == OP_UNMAP) begin
               mem_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = leaf_value;
               if (req_ff.count == COUNT_W'(1)) begin
                  state_in = S_DONE;
               end else begin
                  req_in.count = req_ff.count - COUNT_W'(1);
                  req_in.vpn   = req_ff.vpn + (is_2m ? VPN_STEP_2M : VPN_STEP_4K);
                  req_in.ppn   = req_ff.ppn + (is_2m ? PPN_STEP_2M : PPN_STEP_4K);
                  parent_in    = '0;
                  level_in     = LVL_ROOT;
                  state_in     = S_READ;
               end
            end
         end
         S_LOOK: begin
            value_in = mem_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         free_ff  <= FREE_W'(1);
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      level_ff  <= level_in;
      parent_ff <= parent_in;
      child_ff  <= child_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

endmodule
